[hdl/assert_macros.svh]
// Shared assertion macros for the slice block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/tpss_pkg.sv]
`default_nettype none
package tpss_pkg;

  localparam int DIV_STEPS   = 33;
  localparam int BACK_LAT    = DIV_STEPS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic [32:0]        mag_t;

  typedef struct packed {
    coord_t p0x;
    coord_t p0y;
    diff_t  dx;
    diff_t  dy;
    diff_t  num;
    diff_t  den;
  } edge_t;

  typedef struct packed {
    logic   ok;
    coord_t h;
    edge_t  first;
    edge_t  second;
  } item_t;

  localparam edge_t ZERO_EDGE = '{p0x: '0, p0y: '0, dx: '0, dy: '0, num: '0, den: 33'sd1};

  function automatic mag_t mag33(diff_t v);
    mag33 = v[32] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage
`default_nettype wire

[hdl/tpss_front.sv]
`default_nettype none
`include "assert_macros.svh"
module tpss_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire tpss_pkg::coord_t v0_x,
  input  wire tpss_pkg::coord_t v0_y,
  input  wire tpss_pkg::coord_t v0_z,
  input  wire tpss_pkg::coord_t v1_x,
  input  wire tpss_pkg::coord_t v1_y,
  input  wire tpss_pkg::coord_t v1_z,
  input  wire tpss_pkg::coord_t v2_x,
  input  wire tpss_pkg::coord_t v2_y,
  input  wire tpss_pkg::coord_t v2_z,
  input  wire tpss_pkg::coord_t plane_height,
  output logic                 push,
  output tpss_pkg::item_t      item
);

  tpss_pkg::edge_t  e0, e1, e2;
  tpss_pkg::coord_t h;
  logic             vld;

  // Edge i runs from vertex i to the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= take;
    end
    h <= plane_height;
    e0 <= '{p0x: v0_x, p0y: v0_y,
            dx: tpss_pkg::diff_t'(v1_x) - tpss_pkg::diff_t'(v0_x),
            dy: tpss_pkg::diff_t'(v1_y) - tpss_pkg::diff_t'(v0_y),
            num: tpss_pkg::diff_t'(plane_height) - tpss_pkg::diff_t'(v0_z),
            den: tpss_pkg::diff_t'(v1_z) - tpss_pkg::diff_t'(v0_z)};
    e1 <= '{p0x: v1_x, p0y: v1_y,
            dx: tpss_pkg::diff_t'(v2_x) - tpss_pkg::diff_t'(v1_x),
            dy: tpss_pkg::diff_t'(v2_y) - tpss_pkg::diff_t'(v1_y),
            num: tpss_pkg::diff_t'(plane_height) - tpss_pkg::diff_t'(v1_z),
            den: tpss_pkg::diff_t'(v2_z) - tpss_pkg::diff_t'(v1_z)};
    e2 <= '{p0x: v2_x, p0y: v2_y,
            dx: tpss_pkg::diff_t'(v0_x) - tpss_pkg::diff_t'(v2_x),
            dy: tpss_pkg::diff_t'(v0_y) - tpss_pkg::diff_t'(v2_y),
            num: tpss_pkg::diff_t'(plane_height) - tpss_pkg::diff_t'(v2_z),
            den: tpss_pkg::diff_t'(v0_z) - tpss_pkg::diff_t'(v2_z)};
  end

  tpss_pkg::mag_t  s0, s1, s2, span_a;
  logic [1:0]      a;
  tpss_pkg::edge_t la, lb, lc, oth;
  logic            ok, down, cbelow, cat;

  always_comb begin
    s0 = tpss_pkg::mag33(e0.den);
    s1 = tpss_pkg::mag33(e1.den);
    s2 = tpss_pkg::mag33(e2.den);
    // ties go to the later edge
    a = 2'd0;
    span_a = s0;
    if (s1 >= span_a) begin
      a = 2'd1;
      span_a = s1;
    end
    if (s2 >= span_a) begin
      a = 2'd2;
      span_a = s2;
    end
    case (a)
      2'd0: begin
        la = e0; lb = e1; lc = e2;
      end
      2'd1: begin
        la = e1; lb = e2; lc = e0;
      end
      default: begin
        la = e2; lb = e0; lc = e1;
      end
    endcase
    ok = (span_a != '0) &&
         ((la.num <= 0 && lb.num >= 0) || (la.num >= 0 && lb.num <= 0));
    down   = la.den[32];
    cbelow = lc.num > 0;
    cat    = lc.num == '0;
    if (cat) begin
      oth = '{p0x: lc.p0x, p0y: lc.p0y, dx: '0, dy: '0, num: '0, den: 33'sd1};
    end else if (down ^ cbelow) begin
      oth = lb;
    end else begin
      oth = lc;
    end
    push = vld;
    if (ok) begin
      item.ok     = 1'b1;
      item.h      = h;
      item.first  = down ? la : oth;
      item.second = down ? oth : la;
    end else begin
      item.ok     = 1'b0;
      item.h      = '0;
      item.first  = tpss_pkg::ZERO_EDGE;
      item.second = tpss_pkg::ZERO_EDGE;
    end
  end

  `ASSERT_CLK(a_den_nonzero, (push && item.ok) |-> (item.first.den != '0 && item.second.den != '0),
    "cut edge with zero z span")

endmodule
`default_nettype wire

[hdl/tpss_queue.sv]
`default_nettype none
`include "assert_macros.svh"
module tpss_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tpss_pkg::item_t wdata,
  output logic                 pop,
  output tpss_pkg::item_t      rdata,
  output logic                 full
);

  localparam int AW = tpss_pkg::QUEUE_AW;

  tpss_pkg::item_t mem [tpss_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     count;

  always_comb begin
    pop   = count != '0;
    full  = count == (AW+1)'(tpss_pkg::QUEUE_DEPTH);
    rdata = mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(tpss_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(tpss_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push && full), "request pushed into a full queue")
  `ASSERT_CLK(a_count_range, count <= (AW+1)'(tpss_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

[hdl/tpss_lerp.sv]
`default_nettype none
module tpss_lerp (
  input  wire logic             clk,
  input  wire tpss_pkg::coord_t p0,
  input  wire tpss_pkg::diff_t  d,
  input  wire tpss_pkg::diff_t  num,
  input  wire tpss_pkg::diff_t  den,
  output tpss_pkg::coord_t      res
);

  localparam int N = tpss_pkg::DIV_STEPS;

  tpss_pkg::mag_t  ud0, un0, uden0, ua, uc;
  logic            neg0;
  tpss_pkg::coord_t p00;

  always_comb begin
    ua = tpss_pkg::mag33(num);
    uc = tpss_pkg::mag33(den);
  end

  // magnitudes, clamp the numerator to the denominator
  always_ff @(posedge clk) begin
    ud0   <= tpss_pkg::mag33(d);
    un0   <= (ua > uc) ? uc : ua;
    uden0 <= uc;
    neg0  <= d[32] ^ num[32] ^ den[32];
    p00   <= p0;
  end

  tpss_pkg::mag_t   rem  [N+1];
  tpss_pkg::mag_t   low  [N+1];
  tpss_pkg::mag_t   uden [N+1];
  logic             neg  [N+1];
  tpss_pkg::coord_t p0s  [N+1];

  logic [65:0] prod;
  assign prod = ud0 * un0;

  always_ff @(posedge clk) begin
    rem[0]  <= prod[65:33];
    low[0]  <= prod[32:0];
    uden[0] <= uden0;
    neg[0]  <= neg0;
    p0s[0]  <= p00;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_div
    logic [33:0] t;
    logic        qb;
    always_comb begin
      t  = {rem[k], low[k][32]};
      qb = t >= {1'b0, uden[k]};
    end
    always_ff @(posedge clk) begin
      rem[k+1]  <= qb ? 33'(t - {1'b0, uden[k]}) : t[32:0];
      low[k+1]  <= {low[k][31:0], qb};
      uden[k+1] <= uden[k];
      neg[k+1]  <= neg[k];
      p0s[k+1]  <= p0s[k];
    end
  end

  logic        up;
  logic [31:0] qq;
  always_comb begin
    up = rem[N] >= (uden[N] - rem[N]);
    qq = low[N][31:0] + 32'(up);
  end

  always_ff @(posedge clk) begin
    res <= neg[N] ? p0s[N] - qq : p0s[N] + qq;
  end

endmodule
`default_nettype wire

[hdl/tpss_back.sv]
`default_nettype none
`include "assert_macros.svh"
module tpss_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop,
  input  wire tpss_pkg::item_t item,
  output logic                 done,
  output tpss_pkg::coord_t     first_x,
  output tpss_pkg::coord_t     first_y,
  output tpss_pkg::coord_t     first_z,
  output tpss_pkg::coord_t     second_x,
  output tpss_pkg::coord_t     second_y,
  output tpss_pkg::coord_t     second_z,
  output logic                 cut_valid
);

  localparam int L = tpss_pkg::BACK_LAT;

  tpss_lerp u_fx (.clk, .p0(item.first.p0x), .d(item.first.dx),
                  .num(item.first.num), .den(item.first.den), .res(first_x));
  tpss_lerp u_fy (.clk, .p0(item.first.p0y), .d(item.first.dy),
                  .num(item.first.num), .den(item.first.den), .res(first_y));
  tpss_lerp u_sx (.clk, .p0(item.second.p0x), .d(item.second.dx),
                  .num(item.second.num), .den(item.second.den), .res(second_x));
  tpss_lerp u_sy (.clk, .p0(item.second.p0y), .d(item.second.dy),
                  .num(item.second.num), .den(item.second.den), .res(second_y));

  // carry the strobe, flag and height alongside the lanes
  logic [L-1:0]     vld;
  logic             okp [L];
  tpss_pkg::coord_t hp  [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[L-2:0], pop};
    end
    okp[0] <= item.ok;
    hp[0]  <= item.h;
    for (int i = 1; i < L; i++) begin
      okp[i] <= okp[i-1];
      hp[i]  <= hp[i-1];
    end
  end

  assign done      = vld[L-1];
  assign cut_valid = okp[L-1];
  assign first_z   = hp[L-1];
  assign second_z  = hp[L-1];

  `ASSERT_CLK(a_zero_on_miss, (done && !cut_valid) |->
    (first_x == '0 && first_y == '0 && second_x == '0 && second_y == '0 && first_z == '0),
    "missed cut with nonzero coordinates")

endmodule
`default_nettype wire

[hdl/triangle_plane_slice_segment_top.sv]
`default_nettype none
// Cuts one triangle (Q16.16 vertices) with the plane z = plane_height and returns
// the segment endpoints. One request is taken per cycle whenever busy is low; each
// result passes the front registers, which capture the edges on the edge that takes
// its request, one queue register, then the 36-stage interpolation pipeline:
// magnitude, 33x33 multiply, 33 one-bit divide stages, rounding; done is high for
// exactly one cycle. Results cannot be held off, so the receiver must take
// them on the done cycle. A miss or a flat triangle returns cut_valid low and all
// coordinates zero.
module triangle_plane_slice_segment_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tpss_pkg::coord_t v0_x,
  input  wire tpss_pkg::coord_t v0_y,
  input  wire tpss_pkg::coord_t v0_z,
  input  wire tpss_pkg::coord_t v1_x,
  input  wire tpss_pkg::coord_t v1_y,
  input  wire tpss_pkg::coord_t v1_z,
  input  wire tpss_pkg::coord_t v2_x,
  input  wire tpss_pkg::coord_t v2_y,
  input  wire tpss_pkg::coord_t v2_z,
  input  wire tpss_pkg::coord_t plane_height,
  output logic                  done,
  output tpss_pkg::coord_t      first_x,
  output tpss_pkg::coord_t      first_y,
  output tpss_pkg::coord_t      first_z,
  output tpss_pkg::coord_t      second_x,
  output tpss_pkg::coord_t      second_y,
  output tpss_pkg::coord_t      second_z,
  output logic                  cut_valid
);

  logic            take, push, pop;
  tpss_pkg::item_t fitem, bitem;

  assign take = start && !busy;

  tpss_front u_front (
    .clk, .rst, .take,
    .v0_x, .v0_y, .v0_z, .v1_x, .v1_y, .v1_z, .v2_x, .v2_y, .v2_z,
    .plane_height,
    .push, .item(fitem)
  );

  tpss_queue u_queue (
    .clk, .rst, .push, .wdata(fitem), .pop, .rdata(bitem), .full(busy)
  );

  tpss_back u_back (
    .clk, .rst, .pop, .item(bitem),
    .done, .first_x, .first_y, .first_z, .second_x, .second_y, .second_z, .cut_valid
  );

endmodule
`default_nettype wire

[verif/tb_triangle_plane_slice_segment_top.sv]
`timescale 1ns / 1ps
module tb_triangle_plane_slice_segment_top;

  typedef struct {
    logic signed [31:0] vx[3];
    logic signed [31:0] vy[3];
    logic signed [31:0] vz[3];
    logic signed [31:0] h;
  } tri_req_t;

  typedef struct {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
    logic               ok;
  } segment_t;

  localparam int LATENCY = 37;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst, start, busy, done, cut_valid;
  tpss_pkg::coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, plane_height;
  tpss_pkg::coord_t first_x, first_y, first_z, second_x, second_y, second_z;

  tri_req_t pending_reqs[$];
  segment_t expected_segs[$];
  int errors = 0;
  int n_valid = 0, n_miss = 0, n_checked = 0;
  int cycles = 0;
  int idle_left = 0;
  bit calm = 0;
  bit stim_done = 0;
  bit hold_for_drain = 0;

  triangle_plane_slice_segment_top dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // round(d * num / den) added to p0, halves away from zero, |num| clamped to |den|
  function automatic logic signed [31:0] interp(longint p0, longint p1, longint num,
                                                longint den);
    longint d;
    longint unsigned ud, un, uden, prod, q, r;
    bit neg;
    d = p1 - p0;
    if (den == 0) return p0[31:0];
    ud = d < 0 ? -d : d;
    un = num < 0 ? -num : num;
    uden = den < 0 ? -den : den;
    if (un > uden) un = uden;
    prod = ud * un;
    q = prod / uden;
    r = prod % uden;
    if (r >= uden - r) q++;
    neg = (d < 0) != ((num < 0) != (den < 0));
    return 32'(neg ? (p0 - longint'(q)) : (p0 + longint'(q)));
  endfunction

  function automatic void edge_cut(tri_req_t t, int s, int e, output logic signed [31:0] ox,
                                   output logic signed [31:0] oy);
    longint num, den;
    num = longint'(t.h) - longint'(t.vz[s]);
    den = longint'(t.vz[e]) - longint'(t.vz[s]);
    ox = interp(t.vx[s], t.vx[e], num, den);
    oy = interp(t.vy[s], t.vy[e], num, den);
  endfunction

  function automatic segment_t slice_triangle(tri_req_t t);
    segment_t r;
    longint span[3];
    longint lo, hi, zh;
    int a, b, c;
    logic signed [31:0] lx, ly, ox, oy;
    r = '{default: 0};
    for (int i = 0; i < 3; i++) begin
      span[i] = longint'(t.vz[(i + 1) % 3]) - longint'(t.vz[i]);
      if (span[i] < 0) span[i] = -span[i];
    end
    a = 0;
    if (span[1] >= span[a]) a = 1;
    if (span[2] >= span[a]) a = 2;
    b = (a + 1) % 3;
    c = (a + 2) % 3;
    lo = t.vz[a] < t.vz[b] ? t.vz[a] : t.vz[b];
    hi = t.vz[a] < t.vz[b] ? t.vz[b] : t.vz[a];
    zh = t.h;
    if (span[a] == 0 || zh < lo || zh > hi) return r;
    edge_cut(t, a, b, lx, ly);
    if (t.vz[c] == t.h) begin
      ox = t.vx[c];
      oy = t.vy[c];
    end else if (t.vz[b] < t.vz[a]) begin
      if (t.vz[c] < t.h) edge_cut(t, c, a, ox, oy);
      else edge_cut(t, b, c, ox, oy);
    end else begin
      if (t.vz[c] < t.h) edge_cut(t, b, c, ox, oy);
      else edge_cut(t, c, a, ox, oy);
    end
    if (t.vz[b] < t.vz[a]) begin
      r.fx = lx; r.fy = ly; r.sx = ox; r.sy = oy;
    end else begin
      r.fx = ox; r.fy = oy; r.sx = lx; r.sy = ly;
    end
    r.fz = t.h;
    r.sz = t.h;
    r.ok = 1;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic tri_req_t rnd_tri();
    tri_req_t t;
    int m;
    int pick;
    m = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      t.vx[i] = rnd_coord($urandom_range(0, 9) == 0 ? 3 : m);
      t.vy[i] = rnd_coord($urandom_range(0, 9) == 0 ? 3 : m);
      t.vz[i] = rnd_coord($urandom_range(0, 9) == 0 ? 3 : m);
    end
    // mostly aim the plane inside the triangle, sometimes at a vertex or a tie
    pick = $urandom_range(0, 9);
    if (pick == 0) t.vz[$urandom_range(0, 2)] = t.vz[$urandom_range(0, 2)];
    case ($urandom_range(0, 9))
      0: t.h = rnd_coord(m);
      1, 2: t.h = t.vz[$urandom_range(0, 2)];
      default: begin
        longint lo, hi;
        lo = t.vz[0]; hi = t.vz[0];
        for (int i = 1; i < 3; i++) begin
          if (t.vz[i] < lo) lo = t.vz[i];
          if (t.vz[i] > hi) hi = t.vz[i];
        end
        t.h = lo + longint'(($urandom * 64'd1 * (hi - lo + 1)) >> 32);
      end
    endcase
    return t;
  endfunction

  function automatic tri_req_t mk_tri(longint x0, longint y0, longint z0, longint x1,
                                      longint y1, longint z1, longint x2, longint y2,
                                      longint z2, longint h);
    tri_req_t t;
    t.vx[0] = x0; t.vy[0] = y0; t.vz[0] = z0;
    t.vx[1] = x1; t.vy[1] = y1; t.vz[1] = z1;
    t.vx[2] = x2; t.vy[2] = y2; t.vz[2] = z2;
    t.h = h;
    return t;
  endfunction

  // append a request to the pending list
  function automatic void add_req(tri_req_t t);
    pending_reqs.insert(pending_reqs.size(), t);
  endfunction

  initial begin
    longint mx, mn;
    mx = 64'sh7FFF_FFFF;
    mn = -64'sh8000_0000;
    // descending and ascending long edges
    add_req(mk_tri(0, 0, 65536, 65536, 0, 0, 0, 65536, 32768, 16384));
    add_req(mk_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 32768, 49152));
    // flat triangle
    add_req(mk_tri(5, 6, 100, 7, 8, 100, 9, 10, 100, 100));
    // height below and above the span
    add_req(mk_tri(1, 2, 0, 3, 4, 1000, 5, 6, 500, -1));
    add_req(mk_tri(1, 2, 0, 3, 4, 1000, 5, 6, 500, 1001));
    // height at both ends of the long edge
    add_req(mk_tri(1, 2, 0, 3, 4, 1000, 5, 6, 500, 0));
    add_req(mk_tri(1, 2, 0, 3, 4, 1000, 5, 6, 500, 1000));
    // third vertex at the height
    add_req(mk_tri(10, 20, 0, 30, 40, 1000, 77, 88, 400, 400));
    // tied spans: two tied at the largest, then two tied below the largest
    add_req(mk_tri(0, 0, 0, 100, 0, 100, 0, 100, 0, 50));
    add_req(mk_tri(0, 0, 0, 100, 0, 100, 50, 100, 200, 150));
    // extremes of every field
    add_req(mk_tri(mn, mx, mn, mx, mn, mx, mn, mn, 0, 0));
    add_req(mk_tri(mx, mn, mx, mn, mx, mn, mx, mx, -1, 1));
    add_req(mk_tri(mx, mx, mx, mn, mn, mn, 0, 0, mx, mn));
    add_req(mk_tri(mn, mn, mn, mx, mx, mx, -1, -1, mn, mx));
    add_req(mk_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    add_req(mk_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    // rounding halves on both signs
    add_req(mk_tri(0, 0, 0, 3, -3, 2, 0, 0, 1, 1));
    add_req(mk_tri(0, 0, 2, -3, 3, 0, 9, 9, 1, 1));
    for (int i = 0; i < 930; i++) add_req(rnd_tri());
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      idle_left <= 0;
    end else if (!(start && busy)) begin
      // current request taken or none up
      if (pending_reqs.size() == 0) begin
        start <= 0;
        stim_done <= 1;
      end else if (hold_for_drain && (start || expected_segs.size() != 0)) begin
        start <= 0;
      end else if (idle_left > 0) begin
        start <= 0;
        idle_left <= idle_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        start <= 0;
        idle_left <= $urandom_range(0, 11);
      end else begin
        tri_req_t t;
        t = pending_reqs.pop_front();
        if (pending_reqs.size() == 500) hold_for_drain <= 1;
        else hold_for_drain <= 0;
        if (pending_reqs.size() < 150) calm <= 1;
        start <= 1;
        v0_x <= t.vx[0]; v0_y <= t.vy[0]; v0_z <= t.vz[0];
        v1_x <= t.vx[1]; v1_y <= t.vy[1]; v1_z <= t.vz[1];
        v2_x <= t.vx[2]; v2_y <= t.vy[2]; v2_z <= t.vz[2];
        plane_height <= t.h;
      end
    end
  end

  // note accepted requests
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      tri_req_t t;
      t = mk_tri(v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, plane_height);
      expected_segs.insert(expected_segs.size(), slice_triangle(t));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_segs.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        segment_t e;
        e = expected_segs.pop_front();
        n_checked++;
        if (e.ok) n_valid++; else n_miss++;
        if (first_x !== e.fx) begin
          $error("first_x exp %0d got %0d", e.fx, first_x); errors++;
        end
        if (first_y !== e.fy) begin
          $error("first_y exp %0d got %0d", e.fy, first_y); errors++;
        end
        if (first_z !== e.fz) begin
          $error("first_z exp %0d got %0d", e.fz, first_z); errors++;
        end
        if (second_x !== e.sx) begin
          $error("second_x exp %0d got %0d", e.sx, second_x); errors++;
        end
        if (second_y !== e.sy) begin
          $error("second_y exp %0d got %0d", e.sy, second_y); errors++;
        end
        if (second_z !== e.sz) begin
          $error("second_z exp %0d got %0d", e.sz, second_z); errors++;
        end
        if (cut_valid !== e.ok) begin
          $error("cut_valid exp %0d got %0d", e.ok, cut_valid); errors++;
        end
      end
    end
  end

  initial begin
    rst = 1;
    start = 0;
    {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, plane_height} = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    while (!(stim_done && expected_segs.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_triangle_plane_slice_segment_top failed");
      $finish;
    end else begin
      repeat (LATENCY + 5) @(posedge clk);
      $display("checked %0d segments: %0d cut, %0d missed or flat", n_checked, n_valid,
               n_miss);
      if (errors == 0) $display("tb_triangle_plane_slice_segment_top passed");
      else $display("tb_triangle_plane_slice_segment_top failed");
      $finish;
    end
  end
endmodule
